// ===== design/dlt_pkg.sv =====
package dlt_pkg;

  localparam int ID_W   = 4;
  localparam int DLT_W  = 31;
  localparam int CMD_W  = 2;
  localparam int NUM_IDS = 16;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 2'd0,
    CMD_MOD = 2'd1,
    CMD_DEL = 2'd2,
    CMD_ADV = 2'd3
  } cmd_t;

  // what the travelling token does at the cell that holds it
  typedef enum logic [2:0] {
    TK_FIND = 3'd0,
    TK_INS  = 3'd1,
    TK_SEEK = 3'd2,
    TK_PULL = 3'd3,
    TK_SUB  = 3'd4
  } tok_mode_t;

  typedef struct packed {
    logic             vld;
    tok_mode_t        mode;
    logic [ID_W-1:0]  cid;
    logic [DLT_W-1:0] car;
  } tok_t;

  typedef struct packed {
    logic             occ;
    logic [ID_W-1:0]  id;
    logic [DLT_W-1:0] dlt;
  } ent_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [ID_W-1:0]  timer_id;
    logic [DLT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic             status;
    logic             was_pending;
    logic             expired;
    logic [ID_W-1:0]  expired_id;
    logic [DLT_W-1:0] next_due;
    logic             last;
  } res_t;

endpackage

// ===== design/dlt_cell.sv =====
module dlt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  dlt_pkg::tok_t tok_i,
  input  dlt_pkg::ent_t rgt_i,
  output dlt_pkg::tok_t tok_o,
  output dlt_pkg::ent_t ent_o,
  output logic          fin_o
);
  import dlt_pkg::*;

  tok_t             tok_r;
  ent_t             ent_r;
  ent_t             ent_nxt;
  logic             do_pull;
  logic [DLT_W-1:0] pull_add;

  always_comb begin
    ent_nxt  = ent_r;
    tok_o    = '0;
    fin_o    = 1'b0;
    do_pull  = 1'b0;
    pull_add = '0;
    if (tok_r.vld) begin
      case (tok_r.mode)
        TK_FIND: begin
          if (ent_r.occ && (tok_r.car >= ent_r.dlt)) begin
            tok_o.vld  = 1'b1;
            tok_o.mode = TK_FIND;
            tok_o.cid  = tok_r.cid;
            tok_o.car  = tok_r.car - ent_r.dlt;
          end else begin
            ent_nxt.occ = 1'b1;
            ent_nxt.id  = tok_r.cid;
            ent_nxt.dlt = tok_r.car;
            if (ent_r.occ) begin
              // displaced entry keeps only what is left after the new one
              tok_o.vld  = 1'b1;
              tok_o.mode = TK_INS;
              tok_o.cid  = ent_r.id;
              tok_o.car  = ent_r.dlt - tok_r.car;
            end else begin
              fin_o = 1'b1;
            end
          end
        end
        TK_INS: begin
          ent_nxt.occ = 1'b1;
          ent_nxt.id  = tok_r.cid;
          ent_nxt.dlt = tok_r.car;
          if (ent_r.occ) begin
            tok_o.vld  = 1'b1;
            tok_o.mode = TK_INS;
            tok_o.cid  = ent_r.id;
            tok_o.car  = ent_r.dlt;
          end else begin
            fin_o = 1'b1;
          end
        end
        TK_SEEK: begin
          if (ent_r.occ && (ent_r.id == tok_r.cid)) begin
            do_pull  = 1'b1;
            pull_add = ent_r.dlt;
          end else if (ent_r.occ) begin
            tok_o = tok_r;
          end else begin
            fin_o = 1'b1;
          end
        end
        TK_PULL: begin
          do_pull  = 1'b1;
          pull_add = tok_r.car;
        end
        TK_SUB: begin
          ent_nxt.dlt = ent_r.dlt - tok_r.car;
          fin_o       = 1'b1;
        end
        default: begin
          fin_o = 1'b1;
        end
      endcase
      if (do_pull) begin
        // close the gap: take the right neighbour's entry
        ent_nxt     = rgt_i;
        ent_nxt.dlt = rgt_i.dlt + pull_add;
        if (rgt_i.occ) begin
          tok_o.vld  = 1'b1;
          tok_o.mode = TK_PULL;
          tok_o.cid  = '0;
          tok_o.car  = '0;
        end else begin
          fin_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
      ent_r <= '0;
    end else begin
      tok_r <= tok_i;
      ent_r <= ent_nxt;
    end
  end

  assign ent_o = ent_r;

endmodule

// ===== design/delta_list_timer_queue_unit.sv =====
// add, modify, delete: the result is offered after dispatch, a token walk along the row
//   and the post state; a modify of a queued timer walks the row twice, unlink then
//   re-insert; a busy answer or a delete of an idle slot skips the walk
// advance: each expired timer is reported, then a token walk shifts the row left;
//   one transaction at a time, the token walking the row sets how long it takes
// reset: synchronous, active low; queue empty, every slot idle, no result held
module delta_list_timer_queue_unit #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dlt_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dlt_pkg::res_t     out_data
);
  import dlt_pkg::*;

  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

  // controller states, one-hot
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DISP = 5'b00010,
    S_WAVE = 5'b00100,
    S_ADV  = 5'b01000,
    S_POST = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [DLT_W-1:0]   amt_r, amt_nxt;
  logic               follow_r, follow_nxt;
  res_t               res_r, res_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [NUM_IDS-1:0] act_r, act_nxt;
  logic               out_valid_r;
  res_t               out_data_r;

  logic               post;
  res_t               post_data;
  tok_t               inj;
  logic               id_ok;
  logic               full;
  logic               due_now;
  logic               out_free;
  logic               wave_done;
  ent_t               head;

  // cell row
  tok_t                   tin_q  [TIMER_SLOTS];
  tok_t                   tout_q [TIMER_SLOTS];
  ent_t                   ent_q  [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] fin_vec;
  logic [TIMER_SLOTS-1:0] occ_vec;
  logic [TIMER_SLOTS-1:0] tvld_vec;
  tok_t                   tok_end;

  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    ent_t rgt;
    if (i == TIMER_SLOTS - 1) begin : g_end
      assign rgt = '0;
    end else begin : g_mid
      assign rgt = ent_q[i+1];
    end
    if (i == 0) begin : g_head
      assign tin_q[i] = inj;
    end else begin : g_body
      assign tin_q[i] = tout_q[i-1];
    end
    dlt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tin_q[i]),
      .rgt_i (rgt),
      .tok_o (tout_q[i]),
      .ent_o (ent_q[i]),
      .fin_o (fin_vec[i])
    );
    assign occ_vec[i]  = ent_q[i].occ;
    assign tvld_vec[i] = tin_q[i].vld;
  end

  // the walk never leaves the row while a free cell exists
  assign tok_end = tout_q[TIMER_SLOTS-1];

  assign head      = ent_q[0];
  assign id_ok     = (32'(id_r) < TIMER_SLOTS);
  assign full      = (cnt_r >= CNT_W'(TIMER_SLOTS));
  assign due_now   = head.occ && (head.dlt <= amt_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign wave_done = |fin_vec;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    id_nxt     = id_r;
    amt_nxt    = amt_r;
    follow_nxt = follow_r;
    res_nxt    = res_r;
    cnt_nxt    = cnt_r;
    act_nxt    = act_r;
    inj        = '0;
    post       = 1'b0;
    post_data  = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = cmd_t'(in_data.command);
          id_nxt       = in_data.timer_id;
          amt_nxt      = in_data.amount;
          res_nxt      = '0;
          res_nxt.last = 1'b1;
          state_nxt    = S_DISP;
        end
      end

      S_DISP: begin
        case (cmd_r)
          CMD_ADD: begin
            if (!id_ok || act_r[id_r] || full) begin
              res_nxt.status = ST_BUSY;
              state_nxt      = S_POST;
            end else begin
              inj.vld       = 1'b1;
              inj.mode      = TK_FIND;
              inj.cid       = id_r;
              inj.car       = amt_r;
              act_nxt[id_r] = 1'b1;
              cnt_nxt       = cnt_r + CNT_W'(1);
              state_nxt     = S_WAVE;
            end
          end
          CMD_MOD: begin
            if (!id_ok) begin
              res_nxt.status = ST_BUSY;
              state_nxt      = S_POST;
            end else if (act_r[id_r]) begin
              // unlink first, re-insert once the row has settled
              inj.vld    = 1'b1;
              inj.mode   = TK_SEEK;
              inj.cid    = id_r;
              cnt_nxt    = cnt_r - CNT_W'(1);
              follow_nxt = 1'b1;
              state_nxt  = S_WAVE;
            end else begin
              inj.vld       = 1'b1;
              inj.mode      = TK_FIND;
              inj.cid       = id_r;
              inj.car       = amt_r;
              act_nxt[id_r] = 1'b1;
              cnt_nxt       = cnt_r + CNT_W'(1);
              state_nxt     = S_WAVE;
            end
          end
          CMD_DEL: begin
            if (id_ok && act_r[id_r]) begin
              inj.vld             = 1'b1;
              inj.mode            = TK_SEEK;
              inj.cid             = id_r;
              act_nxt[id_r]       = 1'b0;
              cnt_nxt             = cnt_r - CNT_W'(1);
              res_nxt.was_pending = 1'b1;
              state_nxt           = S_WAVE;
            end else begin
              state_nxt = S_POST;
            end
          end
          CMD_ADV: begin
            state_nxt = S_ADV;
          end
          default: begin
            state_nxt = S_POST;
          end
        endcase
      end

      S_WAVE: begin
        if (wave_done) begin
          if (follow_r) begin
            // second half of a modify
            follow_nxt    = 1'b0;
            inj.vld       = 1'b1;
            inj.mode      = TK_FIND;
            inj.cid       = id_r;
            inj.car       = amt_r;
            cnt_nxt       = cnt_r + CNT_W'(1);
          end else if (cmd_r == CMD_ADV) begin
            state_nxt = S_ADV;
          end else begin
            state_nxt = S_POST;
          end
        end
      end

      S_ADV: begin
        if (out_free) begin
          if (due_now) begin
            // pop the head and report it, then shift the row left
            post                 = 1'b1;
            post_data.expired    = 1'b1;
            post_data.expired_id = head.id;
            amt_nxt              = amt_r - head.dlt;
            inj.vld              = 1'b1;
            inj.mode             = TK_PULL;
            act_nxt[head.id]     = 1'b0;
            cnt_nxt              = cnt_r - CNT_W'(1);
            state_nxt            = S_WAVE;
          end else if (!head.occ) begin
            post           = 1'b1;
            post_data.last = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            // charge the leftover elapsed time to the head
            inj.vld            = 1'b1;
            inj.mode           = TK_SUB;
            inj.car            = amt_r;
            post               = 1'b1;
            post_data.next_due = head.dlt - amt_r;
            post_data.last     = 1'b1;
            state_nxt          = S_IDLE;
          end
        end
      end

      S_POST: begin
        if (out_free) begin
          post      = 1'b1;
          post_data = res_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      follow_r    <= 1'b0;
      cnt_r       <= '0;
      act_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      follow_r <= follow_nxt;
      cnt_r    <= cnt_nxt;
      act_r    <= act_nxt;
      if (post) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // transaction payload and working registers
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    id_r  <= id_nxt;
    amt_r <= amt_nxt;
    res_r <= res_nxt;
    if (post) begin
      out_data_r <= post_data;
    end
  end

  // checks

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !tok_end.vld)
    else $error("token walked off the end of the cell row");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tvld_vec))
    else $error("more than one token in the cell row");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (32'(cnt_r) == $countones(occ_vec)))
    else $error("queue count disagrees with occupied cells");

endmodule

// ===== sim/delta_list_timer_queue_unit_tb.sv =====
`timescale 1ns / 100ps

module delta_list_timer_queue_unit_tb;
  import dlt_pkg::*;

  localparam int               RAND_ITEMS   = 160;
  localparam int               IDLE_LIMIT   = 3000;  // cycles with no transaction on either side
  localparam int               DRAIN_CYCLES = 40;    // longest walk is a modify, unlink then re-insert
  localparam int               HOLD_CYCLES  = 150;   // one long receiver hold-off
  localparam int               HOLD_AFTER   = 60;    // commands sent before the hold-off starts
  localparam logic [DLT_W-1:0] AMT_MAX      = {DLT_W{1'b1}};

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_item_t in_data;
  logic     out_valid;
  logic     out_stall;
  res_t     out_data;

  // one directed row: the command plus, where it is obvious, the single result it gives
  typedef struct packed {
    in_item_t item;
    logic     typed;
    res_t     want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  // predictor copy of the ordered delta list
  logic [ID_W-1:0]  q_id  [NUM_IDS];
  logic [DLT_W-1:0] q_dlt [NUM_IDS];
  int               q_len;
  logic             slot_on [NUM_IDS];

  res_t fresh_results[$];     // results of the command just predicted
  res_t awaited_results[$];   // results still owed by the block, oldest first

  int mismatches;
  int items_sent;
  int results_seen;
  int expiries_seen;
  int idle_cycles;

  delta_list_timer_queue_unit #(
    .TIMER_SLOTS(NUM_IDS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor: the ordered list of (id, delta) with the head counted from now
  // ---------------------------------------------------------------------------

  // close the gap at pos by moving every later entry up by one
  function automatic void pop_at(input int pos);
    for (int i = pos; i + 1 < q_len; i++) begin
      q_id[i]  = q_id[i + 1];
      q_dlt[i] = q_dlt[i + 1];
    end
    q_len--;
  endfunction

  // take a slot out of the list, its delta passes to the successor; 1 if it was queued
  function automatic logic unlink_slot(input logic [ID_W-1:0] id);
    int pos;
    if (!slot_on[id]) return 1'b0;
    pos = 0;
    while (pos < q_len && q_id[pos] != id) pos++;
    if (pos < q_len) begin
      if (pos + 1 < q_len) q_dlt[pos + 1] = q_dlt[pos + 1] + q_dlt[pos];
      pop_at(pos);
    end
    slot_on[id] = 1'b0;
    return 1'b1;
  endfunction

  // insert after all entries due at the same time; busy when the slot is queued already or the list is full
  function automatic logic link_slot(input logic [ID_W-1:0] id, input logic [DLT_W-1:0] due);
    int               pos;
    logic [DLT_W-1:0] rem;
    if (slot_on[id] || q_len >= NUM_IDS) return ST_BUSY;
    rem = due;
    for (pos = 0; pos < q_len; pos++) begin
      if (rem < q_dlt[pos]) begin
        q_dlt[pos] = q_dlt[pos] - rem;
        break;
      end
      rem = rem - q_dlt[pos];
    end
    for (int i = q_len; i > pos; i--) begin
      q_id[i]  = q_id[i - 1];
      q_dlt[i] = q_dlt[i - 1];
    end
    q_id[pos]   = id;
    q_dlt[pos]  = rem;
    q_len++;
    slot_on[id] = 1'b1;
    return ST_OK;
  endfunction

  // works out every result of one accepted command into fresh_results
  function automatic void predict_timer_cmd(input in_item_t it);
    res_t             fin;
    res_t             pop;
    logic [DLT_W-1:0] left;
    fresh_results.delete();
    fin      = '0;
    fin.last = 1'b1;
    case (it.command)
      CMD_ADD: fin.status = link_slot(it.timer_id, it.amount);
      CMD_MOD: begin
        void'(unlink_slot(it.timer_id));
        fin.status = link_slot(it.timer_id, it.amount);
      end
      CMD_DEL: fin.was_pending = unlink_slot(it.timer_id);
      default: begin
        // advance: a head whose delta fits in what is left expires, zero delta included
        left = it.amount;
        while (q_len > 0 && q_dlt[0] <= left) begin
          pop            = '0;
          pop.expired    = 1'b1;
          pop.expired_id = q_id[0];
          left           = left - q_dlt[0];
          slot_on[q_id[0]] = 1'b0;
          pop_at(0);
          fresh_results.push_back(pop);
        end
        if (q_len > 0) begin
          q_dlt[0]     = q_dlt[0] - left;
          fin.next_due = q_dlt[0];
        end
      end
    endcase
    fresh_results.push_back(fin);
  endfunction

  // ---------------------------------------------------------------------------
  // helpers for stimulus and reporting
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatches++;
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // mostly small tick counts so that timers fall due often, with the full range too
  function automatic logic [DLT_W-1:0] pick_amount(input int span);
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return DLT_W'($urandom_range(0, span));
    if (r < 16) return DLT_W'($urandom_range(0, 20 * span));
    if (r < 18) return DLT_W'($urandom);
    if (r < 19) return AMT_MAX;
    return '0;
  endfunction

  function automatic void add_row(input cmd_t cmd, input int id, input logic [DLT_W-1:0] amt,
                                  input logic typed, input logic st, input logic wp,
                                  input logic [DLT_W-1:0] due);
    dir_row_t row;
    row.item.command     = cmd;
    row.item.timer_id    = ID_W'(id);
    row.item.amount      = amt;
    row.typed            = typed;
    row.want             = '0;
    row.want.status      = st;
    row.want.was_pending = wp;
    row.want.next_due    = due;
    row.want.last        = 1'b1;
    dir_rows.push_back(row);
  endfunction

  // offer one transaction, hold it until taken, then book its results
  task automatic send_cmd(input in_item_t it, input logic typed, input res_t want);
    int gap;
    // the first ten of every forty commands go back to back
    gap = (items_sent % 40 < 10) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    predict_timer_cmd(it);
    if (typed) awaited_results.push_back(want);
    else foreach (fresh_results[k]) awaited_results.push_back(fresh_results[k]);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, calm stretches and one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int   hold_left;
    int   stall_left;
    int   calm_left;
    logic held;
    hold_left  = 0;
    stall_left = 0;
    calm_left  = 0;
    held       = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      // long hold-off while the sender keeps offering, so the unit backs up
      if (!held && items_sent >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 49) == 0) calm_left = 40;
        else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // result checker: every accepted result against the oldest one still owed
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.expired) expiries_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing owed", 64'(out_data), 64'(0));
      end else begin
        want = awaited_results.pop_front();
        if (out_data.status != want.status)
          report_mismatch("status", 64'(out_data.status), 64'(want.status));
        if (out_data.was_pending != want.was_pending)
          report_mismatch("was_pending", 64'(out_data.was_pending), 64'(want.was_pending));
        if (out_data.expired != want.expired)
          report_mismatch("expired", 64'(out_data.expired), 64'(want.expired));
        if (out_data.expired_id != want.expired_id)
          report_mismatch("expired_id", 64'(out_data.expired_id), 64'(want.expired_id));
        if (out_data.next_due != want.next_due)
          report_mismatch("next_due", 64'(out_data.next_due), 64'(want.next_due));
        if (out_data.last != want.last)
          report_mismatch("last", 64'(out_data.last), 64'(want.last));
      end
    end
  end

  // watchdog: too long without a transaction on either side ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: %0d cycles without a transaction", idle_cycles);
      $display("FAIL delta_list_timer_queue_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : cmd_source
    in_item_t it;
    int       r;
    mismatches    = 0;
    items_sent    = 0;
    results_seen  = 0;
    expiries_seen = 0;
    q_len         = 0;
    foreach (slot_on[i]) slot_on[i] = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;

    // directed rows; typed expectations only where the answer is plain
    add_row(CMD_ADV,  0, '0,      1'b1, ST_OK,   1'b0, '0);  // advance with nothing queued
    add_row(CMD_DEL,  5, '0,      1'b1, ST_OK,   1'b0, '0);  // delete on an idle slot
    add_row(CMD_ADD,  0, '0,      1'b1, ST_OK,   1'b0, '0);  // due right now
    add_row(CMD_ADD,  0, 31'd5,   1'b1, ST_BUSY, 1'b0, '0);  // already active
    add_row(CMD_ADD, 15, AMT_MAX, 1'b1, ST_OK,   1'b0, '0);
    add_row(CMD_ADD,  1, 31'd100, 1'b0, ST_OK,   1'b0, '0);
    add_row(CMD_ADD,  2, 31'd100, 1'b0, ST_OK,   1'b0, '0);  // ties go behind
    add_row(CMD_ADV,  0, '0,      1'b0, ST_OK,   1'b0, '0);  // zero delta expires at zero ticks
    add_row(CMD_MOD,  1, 31'd50,  1'b0, ST_OK,   1'b0, '0);
    add_row(CMD_MOD,  3, 31'd7,   1'b1, ST_OK,   1'b0, '0);  // modify on an idle slot adds it
    add_row(CMD_DEL,  2, '0,      1'b1, ST_OK,   1'b1, '0);
    add_row(CMD_ADV, 15, AMT_MAX, 1'b0, ST_OK,   1'b0, '0);  // everything expires
    add_row(CMD_ADV,  0, '0,      1'b1, ST_OK,   1'b0, '0);  // empty once more
    add_row(CMD_ADD,  4, 31'd10,  1'b0, ST_OK,   1'b0, '0);
    add_row(CMD_ADD,  5, 31'd10,  1'b0, ST_OK,   1'b0, '0);
    add_row(CMD_ADD,  6, 31'd30,  1'b0, ST_OK,   1'b0, '0);
    add_row(CMD_DEL,  5, '0,      1'b1, ST_OK,   1'b1, '0);  // middle entry, delta to successor
    add_row(CMD_DEL,  4, '0,      1'b1, ST_OK,   1'b1, '0);  // head entry
    add_row(CMD_ADV,  0, 31'd29,  1'b0, ST_OK,   1'b0, '0);  // partial advance of the head
    add_row(CMD_ADV,  0, 31'd1,   1'b0, ST_OK,   1'b0, '0);
    add_row(CMD_ADD,  7, AMT_MAX, 1'b0, ST_OK,   1'b0, '0);
    add_row(CMD_MOD,  7, '0,      1'b0, ST_OK,   1'b0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_cmd(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // random part: adds and advances dominate so the list fills and drains
    for (int n = 0; n < RAND_ITEMS; n++) begin
      r           = $urandom_range(0, 99);
      it.timer_id = ID_W'($urandom_range(0, NUM_IDS - 1));
      if (r < 40) begin
        it.command = CMD_ADD;
        it.amount  = pick_amount(300);
      end else if (r < 55) begin
        it.command = CMD_MOD;
        it.amount  = pick_amount(300);
      end else if (r < 70) begin
        it.command = CMD_DEL;
        it.amount  = DLT_W'($urandom);
      end else begin
        it.command = CMD_ADV;
        it.amount  = pick_amount(120);
      end
      send_cmd(it, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // wait for every owed result, then let any stray result show up
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d timer commands (%0d directed, %0d random), checked %0d results",
             items_sent, dir_rows.size(), RAND_ITEMS, results_seen);
    $display("%0d timers expired, one long result hold-off, %0d mismatches",
             expiries_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS delta_list_timer_queue_unit");
    end else begin
      $display("FAIL delta_list_timer_queue_unit");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dlt_pkg.sv
design/dlt_cell.sv
design/delta_list_timer_queue_unit.sv
sim/delta_list_timer_queue_unit_tb.sv
